### src/wav_header_parser_top_defines.svh
// assertion macros for the wav header parser top level
`ifndef WAV_HEADER_PARSER_TOP_DEFINES_SVH
`define WAV_HEADER_PARSER_TOP_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define WAVP_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wav header parser check failed");

// condition holds in the cycle after the trigger
`define WAVP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wav header parser check failed");

`endif

### src/wavp_pkg.sv
// types and constants of the wav header parser
package wavp_pkg;

    localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
    localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
    localparam logic [31:0] MAGIC_FMT  = 32'h2074_6d66;
    localparam logic [31:0] MAGIC_DATA = 32'h6174_6164;

    localparam logic [31:0] WORD_BYTES = 32'd4;
    localparam logic [31:0] FMT_BYTES  = 32'd16;

    // remaining-byte counts inside the fmt body where a field completes
    localparam logic [31:0] FMT_LEFT_CHANNELS = FMT_BYTES - 32'd4;
    localparam logic [31:0] FMT_LEFT_RATE     = FMT_BYTES - 32'd8;
    localparam logic [31:0] FMT_LEFT_BITS     = 32'd0;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_SIZE,
        PH_WAVE,
        PH_ID,
        PH_LEN,
        PH_FMT,
        PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_RIFF,
        ST_BAD_WAVE,
        ST_NO_DATA
    } t_status;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] bytes_left;
        logic [31:0] gather;
        logic [31:0] chunk_length;
        logic [31:0] byte_position;
        logic [31:0] rate_seen;
        logic [15:0] bits_seen;
        logic [15:0] channels_seen;
        logic        finished;
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [31:0] sample_rate;
        logic [15:0] bits_per_sample;
        logic [15:0] channel_count;
        logic [31:0] payload_offset;
        logic [31:0] payload_size;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:         PH_RIFF,
        bytes_left:    WORD_BYTES,
        gather:        32'd0,
        chunk_length:  32'd0,
        byte_position: 32'd0,
        rate_seen:     32'd0,
        bits_seen:     16'd0,
        channels_seen: 16'd0,
        finished:      1'b0
    };

endpackage

### src/wav_header_parser_top.sv
// wav header parser top level: parse state, result register and handshake
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_stall   i_file_byte, i_end_of_file
//  result    out        o_valid / i_stall   o_status, o_sample_rate, o_bits_per_sample,
//                                           o_channel_count, o_payload_offset,
//                                           o_payload_size
//
// one byte per cycle while o_stall is low; a result appears on o_valid the cycle after the byte that decides it
// the parse state register feeds one pass of compare and counter logic per byte
// i_rst_n is synchronous; after reset the parser waits for the riff magic
// o_stall rises only while a result is held and the downstream side stalls

`include "wav_header_parser_top_defines.svh"

module wav_header_parser_top import wavp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_file_byte,
    input  logic        i_end_of_file,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_sample_rate,
    output logic [15:0] o_bits_per_sample,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_payload_offset,
    output logic [31:0] o_payload_size
);

    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    w_emit;
    logic    w_accept;

    wavp_step u_step (
        .i_state       (r_state),
        .i_file_byte   (i_file_byte),
        .i_end_of_file (i_end_of_file),
        .o_next_state  (n_state),
        .o_emit        (w_emit),
        .o_result      (n_result)
    );

    // a byte may decide a result, so hold off only while the result slot is blocked
    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state <= n_state;
            end
            if (w_accept && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_result <= n_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_result.status;
    assign o_sample_rate     = r_result.sample_rate;
    assign o_bits_per_sample = r_result.bits_per_sample;
    assign o_channel_count   = r_result.channel_count;
    assign o_payload_offset  = r_result.payload_offset;
    assign o_payload_size    = r_result.payload_size;

    // end of file while still parsing always produces a result
    `WAVP_ASSERT_SAME(a_eof_reports, w_accept && i_end_of_file && !r_state.finished, w_emit)

    // nothing is reported while waiting for the end of a finished file
    `WAVP_ASSERT_SAME(a_quiet_when_done, w_accept && r_state.finished, !w_emit)

    // the last byte of a file rearms the parser
    `WAVP_ASSERT_NEXT(a_eof_rearms, w_accept && i_end_of_file, r_state.phase == PH_RIFF && !r_state.finished && r_state.byte_position == 32'd0)

    // failure results carry no format or location
    `WAVP_ASSERT_SAME(a_fail_zero, o_valid && o_status != ST_OK, o_payload_offset == 32'd0 && o_payload_size == 32'd0 && o_sample_rate == 32'd0)

endmodule

### src/wavp_step.sv
// per-byte parse step: next state and result decision
module wavp_step import wavp_pkg::*; (
    input  t_state      i_state,
    input  logic [7:0]  i_file_byte,
    input  logic        i_end_of_file,
    output t_state      o_next_state,
    output logic        o_emit,
    output t_result     o_result
);

    logic [31:0] w_pos;
    logic [31:0] w_gather;
    logic [31:0] w_left;
    logic        w_done;
    logic [31:0] w_fmt_rest;
    logic        w_hit;
    t_status     w_hit_status;

    assign w_pos      = i_state.byte_position + 32'd1;
    assign w_gather   = {i_file_byte, i_state.gather[31:8]};
    assign w_left     = i_state.bytes_left - 32'd1;
    assign w_done     = (w_left == 32'd0);
    assign w_fmt_rest = (i_state.chunk_length > FMT_BYTES) ?
                        (i_state.chunk_length - FMT_BYTES) : 32'd0;

    // decisions completed by this byte
    always_comb begin
        w_hit        = 1'b0;
        w_hit_status = ST_OK;
        if (!i_state.finished && w_done) begin
            unique case (i_state.phase)
                PH_RIFF: begin
                    w_hit        = (w_gather != MAGIC_RIFF);
                    w_hit_status = ST_BAD_RIFF;
                end
                PH_WAVE: begin
                    w_hit        = (w_gather != MAGIC_WAVE);
                    w_hit_status = ST_BAD_WAVE;
                end
                PH_LEN: begin
                    w_hit        = (i_state.chunk_length == MAGIC_DATA);
                    w_hit_status = ST_OK;
                end
                default: begin
                    w_hit        = 1'b0;
                    w_hit_status = ST_OK;
                end
            endcase
        end
    end

    // next state
    always_comb begin
        o_next_state = i_state;
        if (i_state.finished) begin
            if (i_end_of_file) begin
                o_next_state = STATE_RESET;
            end
        end else begin
            o_next_state.byte_position = w_pos;
            o_next_state.gather        = w_gather;
            o_next_state.bytes_left    = w_left;
            unique case (i_state.phase)
                PH_RIFF: begin
                    if (w_done && w_gather == MAGIC_RIFF) begin
                        o_next_state.phase      = PH_SIZE;
                        o_next_state.bytes_left = WORD_BYTES;
                    end
                end
                PH_SIZE: begin
                    if (w_done) begin
                        o_next_state.phase      = PH_WAVE;
                        o_next_state.bytes_left = WORD_BYTES;
                    end
                end
                PH_WAVE: begin
                    if (w_done && w_gather == MAGIC_WAVE) begin
                        o_next_state.phase      = PH_ID;
                        o_next_state.bytes_left = WORD_BYTES;
                    end
                end
                PH_ID: begin
                    if (w_done) begin
                        // chunk id parks in chunk_length until the size arrives
                        o_next_state.chunk_length = w_gather;
                        o_next_state.phase        = PH_LEN;
                        o_next_state.bytes_left   = WORD_BYTES;
                    end
                end
                PH_LEN: begin
                    if (w_done) begin
                        o_next_state.chunk_length = w_gather;
                        if (i_state.chunk_length == MAGIC_DATA) begin
                            o_next_state.phase = PH_LEN;
                        end else if (i_state.chunk_length == MAGIC_FMT) begin
                            o_next_state.phase      = PH_FMT;
                            o_next_state.bytes_left = FMT_BYTES;
                        end else if (w_gather == 32'd0) begin
                            o_next_state.phase      = PH_ID;
                            o_next_state.bytes_left = WORD_BYTES;
                        end else begin
                            o_next_state.phase      = PH_SKIP;
                            o_next_state.bytes_left = w_gather;
                        end
                    end
                end
                PH_FMT: begin
                    if (w_left == FMT_LEFT_CHANNELS) begin
                        o_next_state.channels_seen = w_gather[31:16];
                    end else if (w_left == FMT_LEFT_RATE) begin
                        o_next_state.rate_seen = w_gather;
                    end else if (w_left == FMT_LEFT_BITS) begin
                        o_next_state.bits_seen = w_gather[31:16];
                    end
                    if (w_done) begin
                        if (w_fmt_rest == 32'd0) begin
                            o_next_state.phase      = PH_ID;
                            o_next_state.bytes_left = WORD_BYTES;
                        end else begin
                            o_next_state.phase      = PH_SKIP;
                            o_next_state.bytes_left = w_fmt_rest;
                        end
                    end
                end
                PH_SKIP: begin
                    if (w_done) begin
                        o_next_state.phase      = PH_ID;
                        o_next_state.bytes_left = WORD_BYTES;
                    end
                end
                default: begin
                    o_next_state.phase      = PH_RIFF;
                    o_next_state.bytes_left = WORD_BYTES;
                end
            endcase
            if (i_end_of_file) begin
                o_next_state = STATE_RESET;
            end else if (w_hit) begin
                o_next_state.finished = 1'b1;
            end
        end
    end

    // result
    always_comb begin
        o_emit   = 1'b0;
        o_result = '0;
        if (w_hit) begin
            o_emit          = 1'b1;
            o_result.status = w_hit_status;
            if (w_hit_status == ST_OK) begin
                o_result.sample_rate     = i_state.rate_seen;
                o_result.bits_per_sample = i_state.bits_seen;
                o_result.channel_count   = i_state.channels_seen;
                o_result.payload_offset  = w_pos;
                o_result.payload_size    = w_gather;
            end
        end else if (!i_state.finished && i_end_of_file) begin
            o_emit          = 1'b1;
            o_result.status = ST_NO_DATA;
        end
    end

endmodule

### test/wav_header_parser_checker.sv
// checker for the wav header parser: predicts header results and compares them
module wav_header_parser_checker import wavp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_file_byte,
    input  logic        i_end_of_file,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_sample_rate,
    input  logic [15:0] i_bits_per_sample,
    input  logic [15:0] i_channel_count,
    input  logic [31:0] i_payload_offset,
    input  logic [31:0] i_payload_size,
    output int          o_fail_count,
    output int          o_pending
);

    t_state  parser = STATE_RESET;
    t_result expected_headers[$];
    int      mismatches = 0;

    task automatic skip_chunk(input logic [31:0] len);
        if (len == 32'd0) begin
            parser.phase      = PH_ID;
            parser.bytes_left = WORD_BYTES;
        end else begin
            parser.phase      = PH_SKIP;
            parser.bytes_left = len;
        end
    endtask

    // advance the parse state by one byte, queueing any header result it decides
    task automatic parse_byte(input logic [7:0] b, input logic eof);
        logic        decided;
        logic        done;
        logic [31:0] id;
        t_result     r;
        decided = 1'b0;
        r = '0;
        if (parser.finished) begin
            if (eof) parser = STATE_RESET;
        end else begin
            parser.byte_position = parser.byte_position + 32'd1;
            parser.gather        = {b, parser.gather[31:8]};
            parser.bytes_left    = parser.bytes_left - 32'd1;
            done = (parser.bytes_left == 32'd0);
            case (parser.phase)
                PH_RIFF: begin
                    if (done) begin
                        if (parser.gather != MAGIC_RIFF) begin
                            r.status = ST_BAD_RIFF;
                            decided  = 1'b1;
                        end else begin
                            parser.phase      = PH_SIZE;
                            parser.bytes_left = WORD_BYTES;
                        end
                    end
                end
                PH_SIZE: begin
                    if (done) begin
                        parser.phase      = PH_WAVE;
                        parser.bytes_left = WORD_BYTES;
                    end
                end
                PH_WAVE: begin
                    if (done) begin
                        if (parser.gather != MAGIC_WAVE) begin
                            r.status = ST_BAD_WAVE;
                            decided  = 1'b1;
                        end else begin
                            parser.phase      = PH_ID;
                            parser.bytes_left = WORD_BYTES;
                        end
                    end
                end
                PH_ID: begin
                    if (done) begin
                        parser.chunk_length = parser.gather;
                        parser.phase        = PH_LEN;
                        parser.bytes_left   = WORD_BYTES;
                    end
                end
                PH_LEN: begin
                    if (done) begin
                        // chunk_length still holds the chunk id here
                        id = parser.chunk_length;
                        parser.chunk_length = parser.gather;
                        if (id == MAGIC_DATA) begin
                            r.status          = ST_OK;
                            r.sample_rate     = parser.rate_seen;
                            r.bits_per_sample = parser.bits_seen;
                            r.channel_count   = parser.channels_seen;
                            r.payload_offset  = parser.byte_position;
                            r.payload_size    = parser.chunk_length;
                            decided = 1'b1;
                        end else if (id == MAGIC_FMT) begin
                            parser.phase      = PH_FMT;
                            parser.bytes_left = FMT_BYTES;
                        end else begin
                            skip_chunk(parser.chunk_length);
                        end
                    end
                end
                PH_FMT: begin
                    if (parser.bytes_left == FMT_LEFT_CHANNELS)
                        parser.channels_seen = parser.gather[31:16];
                    else if (parser.bytes_left == FMT_LEFT_RATE)
                        parser.rate_seen = parser.gather;
                    else if (parser.bytes_left == FMT_LEFT_BITS)
                        parser.bits_seen = parser.gather[31:16];
                    if (done) begin
                        skip_chunk(parser.chunk_length > FMT_BYTES ?
                                   parser.chunk_length - FMT_BYTES : 32'd0);
                    end
                end
                PH_SKIP: begin
                    if (done) begin
                        parser.phase      = PH_ID;
                        parser.bytes_left = WORD_BYTES;
                    end
                end
                default: begin
                    parser.phase      = PH_RIFF;
                    parser.bytes_left = WORD_BYTES;
                end
            endcase
            if (!decided && eof) begin
                r = '0;
                r.status = ST_NO_DATA;
                decided = 1'b1;
            end
            if (decided) expected_headers.push_back(r);
            if (eof) parser = STATE_RESET;
            else if (decided) parser.finished = 1'b1;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_header();
        t_result want;
        if (expected_headers.size() == 0) begin
            $display("%0t: unexpected result transaction, expected none, actual status %0d",
                     $time, i_status);
            mismatches++;
        end else begin
            want = expected_headers.pop_front();
            compare_field("status", 32'(want.status), 32'(i_status));
            compare_field("sample_rate", want.sample_rate, i_sample_rate);
            compare_field("bits_per_sample", 32'(want.bits_per_sample),
                          32'(i_bits_per_sample));
            compare_field("channel_count", 32'(want.channel_count), 32'(i_channel_count));
            compare_field("payload_offset", want.payload_offset, i_payload_offset);
            compare_field("payload_size", want.payload_size, i_payload_size);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parser = STATE_RESET;
            expected_headers.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_header();
            if (i_in_valid && !i_in_stall) parse_byte(i_file_byte, i_end_of_file);
        end
        o_pending    <= expected_headers.size();
        o_fail_count <= mismatches;
    end

endmodule

### test/testbench.sv
// testbench top for the wav header parser: file stimulus, watchdog and verdict
module testbench import wavp_pkg::*;;

    localparam int IDLE_LIMIT   = 1000;
    localparam int TARGET_BYTES = 1850;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_file_byte;
    logic        i_end_of_file;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_sample_rate;
    logic [15:0] o_bits_per_sample;
    logic [15:0] o_channel_count;
    logic [31:0] o_payload_offset;
    logic [31:0] o_payload_size;

    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    logic        quiet = 1'b0;
    logic [7:0]  file_bytes[$];

    wav_header_parser_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_file_byte       (i_file_byte),
        .i_end_of_file     (i_end_of_file),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_sample_rate     (o_sample_rate),
        .o_bits_per_sample (o_bits_per_sample),
        .o_channel_count   (o_channel_count),
        .o_payload_offset  (o_payload_offset),
        .o_payload_size    (o_payload_size)
    );

    wav_header_parser_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_file_byte       (i_file_byte),
        .i_end_of_file     (i_end_of_file),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_status          (o_status),
        .i_sample_rate     (o_sample_rate),
        .i_bits_per_sample (o_bits_per_sample),
        .i_channel_count   (o_channel_count),
        .i_payload_offset  (o_payload_offset),
        .i_payload_size    (o_payload_size),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(99) < 21);
    end

    // ends the run if neither channel moves a transaction for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++) file_bytes.push_back(w[8*k +: 8]);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eof);
        while (!quiet && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_file_byte   <= b;
        i_end_of_file <= eof;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_file();
        for (int k = 0; k < file_bytes.size(); k++)
            send_byte(file_bytes[k], k == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // one random file: noise, a broken magic, or a chunk walk that mostly ends in data
    task automatic build_file(output int counted);
        int kind;
        int chunks;
        int len;
        int extra;
        int pick;
        kind = $urandom_range(99);
        if (kind < 12) begin
            len = $urandom_range(1, 30);
            repeat (len) file_bytes.push_back(rand_byte());
            counted = len;
        end else if (kind < 24) begin
            push_word(MAGIC_RIFF);
            push_word(rand_word());
            push_word(MAGIC_WAVE);
            // corrupt one bit of either magic, never the size word
            pick = $urandom_range(0, 7);
            if (pick >= 4) pick += 4;
            file_bytes[pick] = file_bytes[pick] ^ (8'h01 << $urandom_range(0, 7));
            counted = 12;
            repeat ($urandom_range(0, 5)) file_bytes.push_back(rand_byte());
        end else begin
            push_word(MAGIC_RIFF);
            push_word(rand_word());
            push_word(MAGIC_WAVE);
            chunks = $urandom_range(0, 3);
            repeat (chunks) begin
                if ($urandom_range(1) == 0) begin
                    case ($urandom_range(0, 7))
                        0, 1, 2, 3: len = 16;
                        4:          len = $urandom_range(0, 15);
                        5:          len = 18;
                        6:          len = $urandom_range(17, 40);
                        default:    len = 0;
                    endcase
                    extra = (len > 16) ? len - 16 : 0;
                    push_word(MAGIC_FMT);
                    push_word(len);
                    repeat (16 + extra) file_bytes.push_back(rand_byte());
                end else begin
                    len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
                    push_word(rand_word());
                    push_word(len);
                    repeat (len) file_bytes.push_back(rand_byte());
                end
            end
            pick = $urandom_range(0, 9);
            if (pick == 1) begin
                // data size cut short by the end of the file
                push_word(MAGIC_DATA);
                repeat ($urandom_range(0, 3)) file_bytes.push_back(rand_byte());
            end else if (pick > 1) begin
                push_word(MAGIC_DATA);
                push_word(rand_word());
            end
            counted = file_bytes.size();
            if (pick > 1) repeat ($urandom_range(0, 6)) file_bytes.push_back(rand_byte());
        end
    endtask

    initial begin
        int sent;
        int counted;
        int file_count;
        sent = 0;
        file_count = 0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_file_byte   <= 8'h00;
        i_end_of_file <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bad riff magic decided on the last byte of the file
        push_word(MAGIC_RIFF ^ 32'h1E00_0000);
        send_file();
        // end of file on the very first byte
        file_bytes.push_back(8'hFF);
        send_file();
        // bad wave magic, then bytes ignored until the end of the file
        push_word(MAGIC_RIFF);
        push_word(32'hFFFF_FFFF);
        push_word(MAGIC_WAVE ^ 32'h1D00_0000);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        send_file();

        while (sent < TARGET_BYTES) begin
            build_file(counted);
            if (file_count % 8 == 3) drain_results();
            quiet = (sent >= 600 && sent < 1000);
            send_file();
            sent += counted;
            file_count++;
        end
        quiet = 1'b0;

        drain_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
